>>> rtl/psg_pkg.sv
// psg_pkg: shared widths, register select codes, amplitude table and noise constants
// for the tone/noise sound generator; no dependencies
`default_nettype none

package psg_pkg;

    localparam int unsigned PerW    = 10;  // tone period width
    localparam int unsigned CntW    = 11;  // noise countdown width (twice the period)
    localparam int unsigned AmpW    = 15;  // linear channel amplitude
    localparam int unsigned MixW    = 17;  // sum of four amplitudes
    localparam int unsigned ChargeW = 32;  // high-pass integrator
    localparam int unsigned SmpW    = 16;  // output sample
    localparam int unsigned LfsrW   = 16;

    localparam int unsigned HpfShift = 14;
    localparam int unsigned OutShift = 11;

    localparam logic [LfsrW-1:0] NoiseSeed     = 16'h8000;
    localparam logic [AmpW-1:0]  AmpReset      = 15'd15;
    localparam logic [PerW-1:0]  NoisePerReset = 10'd16;
    localparam logic [PerW-1:0]  NoisePer16    = 10'h010;
    localparam logic [PerW-1:0]  NoisePer32    = 10'h020;
    localparam logic [PerW-1:0]  NoisePer64    = 10'h040;

    // register select, bits 6:4 of a latch byte
    typedef enum logic [2:0] {
        REG_TONE0 = 3'd0,
        REG_VOL0  = 3'd1,
        REG_TONE1 = 3'd2,
        REG_VOL1  = 3'd3,
        REG_TONE2 = 3'd4,
        REG_VOL2  = 3'd5,
        REG_NOISE = 3'd6,
        REG_VOL3  = 3'd7
    } t_reg_sel;

    typedef enum logic [1:0] {
        RATE_16    = 2'd0,
        RATE_32    = 2'd1,
        RATE_64    = 2'd2,
        RATE_TONE2 = 2'd3
    } t_noise_rate;

    // noise control from the register file to the noise channel
    typedef struct packed {
        logic            reload;        // noise control write this cycle
        logic            white;         // lfsr mode, else periodic
        logic [CntW-1:0] reload_count;  // countdown value on a noise write
    } t_noise_ctl;

    // attenuation code to linear amplitude, last code is silence
    function automatic logic [AmpW-1:0] amp_lookup(input logic [3:0] code);
        logic [AmpW-1:0] amp;
        case (code)
            4'd0:    amp = 15'd16384;
            4'd1:    amp = 15'd13014;
            4'd2:    amp = 15'd10338;
            4'd3:    amp = 15'd8211;
            4'd4:    amp = 15'd6523;
            4'd5:    amp = 15'd5181;
            4'd6:    amp = 15'd4115;
            4'd7:    amp = 15'd3269;
            4'd8:    amp = 15'd2597;
            4'd9:    amp = 15'd2063;
            4'd10:   amp = 15'd1638;
            4'd11:   amp = 15'd1301;
            4'd12:   amp = 15'd1034;
            4'd13:   amp = 15'd821;
            4'd14:   amp = 15'd652;
            default: amp = 15'd0;
        endcase
        return amp;
    endfunction

endpackage

`default_nettype wire

>>> rtl/psg_regs.sv
// psg_regs: byte write decoder and register file (periods, amplitudes, noise control)
// depends on psg_pkg
`default_nettype none

module psg_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_wr,
    input  wire logic [7:0]                            i_byte,
    output logic [3:0][psg_pkg::PerW-1:0]              o_period,
    output logic [3:0][psg_pkg::AmpW-1:0]              o_amp,
    output psg_pkg::t_noise_ctl                        o_noise
);

    logic [3:0][psg_pkg::PerW-1:0] r_period, n_period;
    logic [3:0][psg_pkg::AmpW-1:0] r_amp, n_amp;
    logic [2:0]                    r_nctl, n_nctl;
    logic [7:0]                    r_latch, n_latch;

    logic                          c_do_latch;
    logic [7:0]                    c_eff;
    psg_pkg::t_reg_sel             c_sel;
    psg_pkg::t_reg_sel             c_sel_lat;
    logic                          c_tone_hit;
    logic [1:0]                    c_tone_idx;
    logic [psg_pkg::PerW-1:0]      c_tone_val;
    logic                          c_reload;

    always_comb begin
        c_sel_lat  = psg_pkg::t_reg_sel'(r_latch[6:4]);
        // data byte for a volume or noise latch acts as a latch of its own
        c_do_latch = i_byte[7] || !(c_sel_lat inside {psg_pkg::REG_TONE0,
                                                      psg_pkg::REG_TONE1,
                                                      psg_pkg::REG_TONE2});
        c_eff      = i_byte[7] ? i_byte : {r_latch[7:4], i_byte[3:0]};
        c_sel      = psg_pkg::t_reg_sel'(c_eff[6:4]);

        n_period   = r_period;
        n_amp      = r_amp;
        n_nctl     = r_nctl;
        n_latch    = r_latch;
        c_tone_hit = 1'b0;
        c_tone_idx = c_sel_lat[2:1];
        c_tone_val = {i_byte[5:0], r_period[c_sel_lat[2:1]][3:0]};
        c_reload   = 1'b0;

        if (i_wr) begin
            if (c_do_latch) begin
                n_latch = c_eff;
                unique case (c_sel) inside
                    psg_pkg::REG_TONE0, psg_pkg::REG_TONE1, psg_pkg::REG_TONE2: begin
                        c_tone_hit = 1'b1;
                        c_tone_idx = c_sel[2:1];
                        c_tone_val = {r_period[c_sel[2:1]][9:4], c_eff[3:0]};
                    end
                    psg_pkg::REG_NOISE: begin
                        c_reload = 1'b1;
                        n_nctl   = c_eff[2:0];
                        case (psg_pkg::t_noise_rate'(c_eff[1:0]))
                            psg_pkg::RATE_16: n_period[3] = psg_pkg::NoisePer16;
                            psg_pkg::RATE_32: n_period[3] = psg_pkg::NoisePer32;
                            psg_pkg::RATE_64: n_period[3] = psg_pkg::NoisePer64;
                            default:          n_period[3] = r_period[2];
                        endcase
                    end
                    default: begin
                        n_amp[c_sel[2:1]] = psg_pkg::amp_lookup(c_eff[3:0]);
                    end
                endcase
            end else begin
                c_tone_hit = 1'b1;
            end

            if (c_tone_hit) begin
                n_period[c_tone_idx] = c_tone_val;
                // tone 2 drives the noise rate in linked mode
                if (c_tone_idx == 2'd2 &&
                    psg_pkg::t_noise_rate'(r_nctl[1:0]) == psg_pkg::RATE_TONE2) begin
                    n_period[3] = c_tone_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= {psg_pkg::NoisePerReset, {3{{psg_pkg::PerW{1'b0}}}}};
            r_amp    <= {4{psg_pkg::AmpReset}};
            r_nctl   <= 3'd0;
            r_latch  <= 8'd0;
        end else begin
            r_period <= n_period;
            r_amp    <= n_amp;
            r_nctl   <= n_nctl;
            r_latch  <= n_latch;
        end
    end

    assign o_period             = r_period;
    assign o_amp                = r_amp;
    assign o_noise.reload       = c_reload;
    assign o_noise.white        = r_nctl[2];
    assign o_noise.reload_count = {n_period[3], 1'b0};

endmodule

`default_nettype wire

>>> rtl/psg_tone.sv
// psg_tone: one square-wave tone channel, countdown and level bit
// depends on psg_pkg
`default_nettype none

module psg_tone (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_tick,
    input  wire logic [psg_pkg::PerW-1:0] i_period,
    output logic                          o_on
);

    logic [psg_pkg::PerW-1:0] r_count, n_count;
    logic                     r_high, n_high;
    logic                     c_steady;
    logic [psg_pkg::PerW-1:0] c_base;

    always_comb begin
        // period 0 or 1 holds the output on
        c_steady = (i_period[psg_pkg::PerW-1:1] == '0);
        c_base   = (r_count == '0) ? i_period : r_count;
        n_count  = r_count;
        n_high   = r_high;
        if (i_tick && !c_steady) begin
            n_count = c_base - 1'b1;
            if (r_count == '0) begin
                n_high = ~r_high;
            end
        end
        o_on = c_steady | n_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_high  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_high  <= n_high;
        end
    end

endmodule

`default_nettype wire

>>> rtl/psg_noise.sv
// psg_noise: noise channel with periodic 1-in-16 pattern and 16-bit lfsr
// depends on psg_pkg
`default_nettype none

module psg_noise (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_tick,
    input  wire logic [psg_pkg::PerW-1:0] i_period,
    input  wire psg_pkg::t_noise_ctl      i_ctl,
    output logic                          o_on
);

    logic [psg_pkg::CntW-1:0]  r_count, n_count;
    logic                      r_high, n_high;
    logic [3:0]                r_pos, n_pos;
    logic [psg_pkg::LfsrW-1:0] r_shift, n_shift;
    logic                      c_steady;
    logic [psg_pkg::CntW-1:0]  c_base;

    always_comb begin
        c_steady = (i_period[psg_pkg::PerW-1:1] == '0);
        c_base   = (r_count == '0) ? {i_period, 1'b0} : r_count;
        n_count  = r_count;
        n_high   = r_high;
        n_pos    = r_pos;
        n_shift  = r_shift;
        if (i_ctl.reload) begin
            n_count = i_ctl.reload_count;
            n_pos   = 4'd0;
            n_shift = psg_pkg::NoiseSeed;
        end else if (i_tick && !c_steady) begin
            n_count = c_base - 1'b1;
            if (r_count == '0) begin
                if (!i_ctl.white) begin
                    n_pos  = r_pos + 4'd1;
                    n_high = (r_pos == 4'd14);
                end else begin
                    // feedback from taps 0 and 3 into the top bit
                    n_shift = {r_shift[0] ^ r_shift[3], r_shift[psg_pkg::LfsrW-1:1]};
                    n_high  = r_shift[1];
                end
            end
        end
        o_on = c_steady | n_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_high  <= 1'b0;
            r_pos   <= 4'd0;
            r_shift <= psg_pkg::NoiseSeed;
        end else begin
            r_count <= n_count;
            r_high  <= n_high;
            r_pos   <= n_pos;
            r_shift <= n_shift;
        end
    end

    // a noise control write restarts both patterns
    a_reload_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.reload |=> (r_shift == psg_pkg::NoiseSeed) && (r_pos == 4'd0))
        else $error("noise write did not reseed the pattern");

endmodule

`default_nettype wire

>>> rtl/psg_hpf.sv
// psg_hpf: first-order high-pass on the channel mix, rounding and 16-bit saturation
// depends on psg_pkg
`default_nettype none

module psg_hpf (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_tick,
    input  wire logic [psg_pkg::MixW-1:0] i_mix,
    output logic signed [psg_pkg::SmpW-1:0] o_sample
);

    localparam int unsigned WideW = psg_pkg::ChargeW + 1;

    logic signed [psg_pkg::ChargeW-1:0] r_charge, n_charge;
    logic signed [WideW-1:0]            c_mix;
    logic signed [WideW-1:0]            c_diff;
    logic signed [WideW-1:0]            c_step;
    logic signed [WideW-1:0]            c_out;
    logic signed [WideW-1:0]            c_shifted;

    always_comb begin
        c_mix     = $signed({{(WideW - psg_pkg::MixW - 8){1'b0}}, i_mix, 8'd0});
        c_diff    = c_mix - $signed({r_charge[psg_pkg::ChargeW-1], r_charge});
        c_step    = c_diff >>> psg_pkg::HpfShift;
        n_charge  = r_charge + $signed(c_step[psg_pkg::ChargeW-1:0]);
        c_out     = c_mix - $signed({n_charge[psg_pkg::ChargeW-1], n_charge})
                    + $signed(WideW'(256));
        c_shifted = c_out >>> psg_pkg::OutShift;
        if (!c_shifted[WideW-1] && (|c_shifted[WideW-2:psg_pkg::SmpW-1])) begin
            o_sample = 16'sh7FFF;
        end else if (c_shifted[WideW-1] && !(&c_shifted[WideW-2:psg_pkg::SmpW-1])) begin
            o_sample = -16'sh8000;
        end else begin
            o_sample = c_shifted[psg_pkg::SmpW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge <= '0;
        end else if (i_tick) begin
            r_charge <= n_charge;
        end
    end

endmodule

`default_nettype wire

>>> rtl/psg_tone_noise_generator_core.sv
// psg_tone_noise_generator_core: top level of the four-channel tone/noise generator
// depends on psg_pkg, psg_regs, psg_tone, psg_noise, psg_hpf
`default_nettype none

// channel   ports                                           moves
// --------  ----------------------------------------------  -------------------------------
// input     i_in_valid, o_in_ready, i_action, i_data_byte   byte write or sample tick
// output    o_out_valid, i_out_ready, o_sample              one sample per tick transfer
//
// an accepted item sits in the input register, then the decode writes the register
// file, or the channel step, mix and filter run and load the result register
// one item per cycle unless a tick stalls; a tick passes input then result register
// a write item makes no sample and never waits on the output side
// a tick item waits in the input register while an unread sample is held
// synchronous active-low reset restores the power-up register and channel state
module psg_tone_noise_generator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_action,
    input  wire logic [7:0]                  i_data_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [psg_pkg::SmpW-1:0]  o_sample
);

    // input register
    logic       r_in_valid;
    logic       r_action;
    logic [7:0] r_byte;

    // result register
    logic                             r_out_valid;
    logic signed [psg_pkg::SmpW-1:0]  r_sample;

    logic c_out_free;
    logic c_consume;
    logic c_tick;
    logic c_wr;

    logic [3:0][psg_pkg::PerW-1:0] w_period;
    logic [3:0][psg_pkg::AmpW-1:0] w_amp;
    psg_pkg::t_noise_ctl           w_noise;
    logic [3:0]                    w_on;
    logic [psg_pkg::MixW-1:0]      c_mix;
    logic signed [psg_pkg::SmpW-1:0] w_sample;

    // writes always drain; a tick drains only when the result register frees up
    assign c_out_free = !r_out_valid || i_out_ready;
    assign c_consume  = r_in_valid && (!r_action || c_out_free);
    assign c_tick     = c_consume && r_action;
    assign c_wr       = c_consume && !r_action;
    assign o_in_ready = !r_in_valid || c_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_byte   <= i_data_byte;
        end
    end

    psg_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (c_wr),
        .i_byte   (r_byte),
        .o_period (w_period),
        .o_amp    (w_amp),
        .o_noise  (w_noise)
    );

    // three square-wave channels
    for (genvar g = 0; g < 3; g++) begin : g_tone
        psg_tone u_tone (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tick   (c_tick),
            .i_period (w_period[g]),
            .o_on     (w_on[g])
        );
    end

    psg_noise u_noise (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (c_tick),
        .i_period (w_period[3]),
        .i_ctl    (w_noise),
        .o_on     (w_on[3])
    );

    // mix of the channels that are high after this step
    always_comb begin
        c_mix = '0;
        for (int k = 0; k < 4; k++) begin
            if (w_on[k]) begin
                c_mix = c_mix + psg_pkg::MixW'(w_amp[k]);
            end
        end
    end

    psg_hpf u_hpf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (c_tick),
        .i_mix    (c_mix),
        .o_sample (w_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_tick) begin
            r_sample <= w_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // every tick that leaves the input register lands in the result register
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_tick |=> r_out_valid)
        else $error("tick transfer produced no sample");

    // a held item keeps its payload until it is processed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !c_consume) |=> r_in_valid && $stable(r_action) && $stable(r_byte))
        else $error("input register changed while stalled");

    // a write never disturbs a sample that is still waiting
    a_wr_keeps_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_wr && r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_sample))
        else $error("write transfer disturbed the pending sample");

endmodule

`default_nettype wire

>>> tb/psg_sample_checker.sv
// psg_sample_checker: watches both channels of psg_tone_noise_generator_core, keeps its
// own model of the channel, noise and filter state, and compares every sample transfer
// depends on psg_pkg for the widths, shifts, register select and noise rate codes and the reset constants
`timescale 1ns / 100ps

module psg_sample_checker
    import psg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic               i_tick,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [15:0] i_sample,
    output int                      o_pending,
    output int                      o_mismatches
);

    logic [PerW-1:0]  period_q    [4];
    logic [AmpW-1:0]  level_q     [4];
    logic [CntW-1:0]  count_q     [4];
    logic             high_q      [4];
    logic [2:0]       noise_ctl_q;
    logic [7:0]       latch_q;
    logic [LfsrW-1:0] lfsr_q;
    logic [3:0]       pulse_pos_q;
    longint           charge_q;

    logic [AmpW-1:0]  atten_level [16];
    logic signed [15:0] samples_due [$];
    int mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    initial begin
        atten_level = '{15'd16384, 15'd13014, 15'd10338, 15'd8211, 15'd6523, 15'd5181,
                        15'd4115, 15'd3269, 15'd2597, 15'd2063, 15'd1638, 15'd1301,
                        15'd1034, 15'd821, 15'd652, 15'd0};
    end

    task automatic clear_state();
        int ch;
        for (ch = 0; ch < 4; ch++) begin
            period_q[ch] = '0;
            level_q[ch]  = AmpReset;
            count_q[ch]  = '0;
            high_q[ch]   = 1'b0;
        end
        period_q[3] = NoisePerReset;
        noise_ctl_q = '0;
        latch_q     = '0;
        lfsr_q      = NoiseSeed;
        pulse_pos_q = '0;
        charge_q    = 0;
    endtask

    // tone 2 also drives the noise rate while the rate field selects it
    task automatic put_tone2(input logic [PerW-1:0] per);
        period_q[2] = per;
        if (noise_ctl_q[1:0] == RATE_TONE2)
            period_q[3] = per;
    endtask

    task automatic apply_latch(input logic [7:0] cmd);
        t_reg_sel sel;
        sel = t_reg_sel'(cmd[6:4]);
        latch_q = cmd;
        case (sel)
            REG_TONE0: period_q[0] = {period_q[0][9:4], cmd[3:0]};
            REG_TONE1: period_q[1] = {period_q[1][9:4], cmd[3:0]};
            REG_TONE2: put_tone2({period_q[2][9:4], cmd[3:0]});
            REG_NOISE: begin
                noise_ctl_q = cmd[2:0];
                pulse_pos_q = '0;
                lfsr_q      = NoiseSeed;
                case (t_noise_rate'(cmd[1:0]))
                    RATE_16:    period_q[3] = NoisePer16;
                    RATE_32:    period_q[3] = NoisePer32;
                    RATE_64:    period_q[3] = NoisePer64;
                    RATE_TONE2: period_q[3] = period_q[2];
                endcase
                count_q[3] = {period_q[3], 1'b0};
            end
            REG_VOL0: level_q[0] = atten_level[cmd[3:0]];
            REG_VOL1: level_q[1] = atten_level[cmd[3:0]];
            REG_VOL2: level_q[2] = atten_level[cmd[3:0]];
            REG_VOL3: level_q[3] = atten_level[cmd[3:0]];
        endcase
    endtask

    task automatic write_byte(input logic [7:0] b);
        if (b[7]) begin
            apply_latch(b);
        end else begin
            case (t_reg_sel'(latch_q[6:4]))
                REG_TONE0: period_q[0] = {b[5:0], period_q[0][3:0]};
                REG_TONE1: period_q[1] = {b[5:0], period_q[1][3:0]};
                REG_TONE2: put_tone2({b[5:0], period_q[2][3:0]});
                // volume or noise latched: the byte acts as a new latch command
                default:   apply_latch({latch_q[7:4], b[3:0]});
            endcase
        end
    endtask

    task automatic step_noise();
        if (!noise_ctl_q[2]) begin
            pulse_pos_q = pulse_pos_q + 4'd1;
            high_q[3]   = (pulse_pos_q == 4'hF);
        end else begin
            lfsr_q    = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[15:1]};
            high_q[3] = lfsr_q[0];
        end
    endtask

    task automatic mix_and_filter(output logic signed [15:0] smp);
        longint mix;
        longint level;
        int ch;
        mix = 0;
        for (ch = 0; ch < 4; ch++) begin
            level = longint'(level_q[ch]);
            if (period_q[ch] <= 1) begin
                // steady channel, always in the mix
                mix = mix + level;
            end else begin
                if (count_q[ch] == 0) begin
                    if (ch == 3) begin
                        count_q[3] = {period_q[3], 1'b0};
                        step_noise();
                    end else begin
                        count_q[ch] = CntW'(period_q[ch]);
                        high_q[ch]  = !high_q[ch];
                    end
                end
                if (count_q[ch] != 0)
                    count_q[ch] = count_q[ch] - 1'b1;
                if (high_q[ch])
                    mix = mix + level;
            end
        end
        mix      = mix * 256;
        charge_q = charge_q + ((mix - charge_q) >>> HpfShift);
        level    = (mix - charge_q + 256) >>> OutShift;
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        smp = 16'(level);
    endtask

    always @(posedge i_clk) begin
        logic signed [15:0] predicted;
        if (!i_rst_n) begin
            clear_state();
            samples_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: sample transfer with none expected, actual %0d",
                             $time, i_sample);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    predicted = samples_due.pop_front();
                    if (i_sample !== predicted) begin
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, predicted, i_sample);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_tick) begin
                    mix_and_filter(predicted);
                    samples_due.push_back(predicted);
                end else begin
                    write_byte(i_data_byte);
                end
            end
        end
        o_pending <= samples_due.size();
    end

endmodule

>>> tb/tb_top.sv
// tb_top: directed and random byte writes and sample ticks into the sound generator core
// with bursty idling on both channels; depends on psg_pkg, psg_sample_checker and the rtl
`timescale 1ns / 100ps

module tb_top;
    import psg_pkg::*;

    localparam logic ACT_WRITE    = 1'b0;
    localparam logic ACT_TICK     = 1'b1;
    localparam int   RANDOM_ITEMS = 1275;
    localparam int   CALM_ITEMS   = 200;
    localparam int   IDLE_LIMIT   = 2000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic action    = ACT_WRITE;
    logic [7:0] data_byte = 8'h00;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic signed [SmpW-1:0] sample;

    logic in_fire   = 1'b0;
    bit   calm      = 1'b0;
    int   idle_cycles = 0;
    int   pending;
    int   mismatches;

    always #10 clk = ~clk;

    psg_tone_noise_generator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_action    (action),
        .i_data_byte (data_byte),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_sample    (sample)
    );

    psg_sample_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_tick       (action),
        .i_data_byte  (data_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_sample     (sample),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // input transfer seen at the last rising edge, read by the driver at the falling edge
    always @(posedge clk) begin
        in_fire <= in_valid && in_ready;
    end

    // no transfer on either side for too long means the block is stuck
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver stalls in random bursts, no new burst starts once the run turns calm
    initial begin : out_stall
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] latch_cmd(input t_reg_sel sel, input logic [3:0] nib);
        return {1'b1, sel, nib};
    endfunction

    // one input transfer; valid stays up into the next item unless a gap is taken
    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= b;
        do @(negedge clk); while (!in_fire);
    endtask

    // mostly ticks and latches; most data bytes keep tone periods short so edges happen often
    task automatic random_item();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_item(ACT_TICK, 8'($urandom_range(0, 255)));
        end else if (pick < 80) begin
            b = latch_cmd(t_reg_sel'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
            send_item(ACT_WRITE, b);
        end else begin
            if ($urandom_range(0, 3) == 0)
                b = 8'($urandom_range(0, 127));
            else
                b = {1'b0, 1'($urandom_range(0, 1)), 4'b0000, 2'($urandom_range(0, 3))};
            send_item(ACT_WRITE, b);
        end
    endtask

    initial begin : stimulus
        int n;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // power-up state: three steady tones at the reset amplitude, noise counting
        send_item(ACT_TICK, 8'hFF);
        // loudest tone 0 at the longest period
        send_item(ACT_WRITE, latch_cmd(REG_VOL0, 4'h0));
        send_item(ACT_WRITE, latch_cmd(REG_TONE0, 4'hF));
        send_item(ACT_WRITE, 8'h3F);
        send_item(ACT_TICK, 8'h00);
        // period 1 makes tone 1 a steady level
        send_item(ACT_WRITE, latch_cmd(REG_TONE1, 4'h1));
        send_item(ACT_WRITE, latch_cmd(REG_VOL1, 4'h0));
        send_item(ACT_TICK, 8'h5A);
        // shortest counting period on tone 2, high bits through a data byte
        send_item(ACT_WRITE, latch_cmd(REG_TONE2, 4'h2));
        send_item(ACT_WRITE, 8'h40);
        // periodic noise tied to tone 2, then a tone 2 write copied into the noise period
        send_item(ACT_WRITE, latch_cmd(REG_NOISE, {2'b00, RATE_TONE2}));
        send_item(ACT_WRITE, latch_cmd(REG_TONE2, 4'h3));
        send_item(ACT_WRITE, latch_cmd(REG_VOL3, 4'h0));
        repeat (4) send_item(ACT_TICK, 8'hA5);
        // white noise, then a data byte taken as a noise command
        send_item(ACT_WRITE, latch_cmd(REG_NOISE, {2'b01, RATE_16}));
        send_item(ACT_WRITE, 8'h07);
        // silence on tone 2, then a data byte taken as a volume command
        send_item(ACT_WRITE, latch_cmd(REG_VOL2, 4'hF));
        send_item(ACT_WRITE, 8'h08);
        send_item(ACT_WRITE, latch_cmd(REG_NOISE, {2'b00, RATE_32}));
        send_item(ACT_WRITE, latch_cmd(REG_NOISE, {2'b01, RATE_64}));
        repeat (2) send_item(ACT_TICK, 8'h3C);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // hold off until the output side has drained
                in_valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            random_item();
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        // room for a stray sample behind the pipeline
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
